// ===== rtl/core/bmpc_pkg.sv =====
// shared types and constants for the button multi-press classifier
`default_nettype none

package bmpc_pkg;

  localparam int unsigned LANES    = 4;
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [COUNT_W-1:0] RELEASE_TICKS_RST = 8'd20;
  localparam logic [COUNT_W-1:0] HOLD_TICKS_RST    = 8'd120;

  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 1'b1;

  typedef enum logic {
    EVT_MULTI = 1'b0,
    EVT_HOLD  = 1'b1
  } evt_kind_e;

  typedef struct packed {
    logic               valid;
    evt_kind_e          kind;
    logic [COUNT_W-1:0] count;
  } lane_evt_t;

endpackage

`default_nettype wire

// ===== rtl/core/bmpc_lane.sv =====
// one button lane: debounce, press counter, timer and event detection
`default_nettype none

module bmpc_lane
  import bmpc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire logic               push_i,
  input  wire logic               first_i,
  input  wire logic [COUNT_W-1:0] release_ticks_i,
  input  wire logic [COUNT_W-1:0] hold_ticks_i,
  output lane_evt_t               evt_o
);

  logic               sampled_q, sampled_d;
  logic               accepted_q, accepted_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] timer_q, timer_d;
  logic [COUNT_W-1:0] limit;

  always_comb begin
    sampled_d  = push_i;
    accepted_d = accepted_q;
    count_d    = count_q;
    timer_d    = timer_q;
    evt_o      = '{valid: 1'b0, kind: EVT_MULTI, count: count_q};
    limit      = push_i ? hold_ticks_i : release_ticks_i;

    if ((sampled_q != push_i) && !first_i) begin
      // still bouncing: only the sample moves
    end else if (first_i || (accepted_q != push_i)) begin
      accepted_d = push_i;
      if (push_i && !first_i && (count_q != COUNT_MAX)) begin
        count_d = count_q + COUNT_W'(1);
      end
      timer_d = '0;
    end else if (count_q != '0) begin
      if (timer_q != COUNT_MAX) begin
        timer_d = timer_q + COUNT_W'(1);
      end
      if (timer_q >= limit) begin
        evt_o.valid = 1'b1;
        evt_o.kind  = push_i ? EVT_HOLD : EVT_MULTI;
        if (!push_i) begin
          count_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sampled_q  <= 1'b0;
      accepted_q <= 1'b0;
      count_q    <= '0;
      timer_q    <= '0;
    end else if (take_i) begin
      sampled_q  <= sampled_d;
      accepted_q <= accepted_d;
      count_q    <= count_d;
      timer_q    <= timer_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bmpc_merge.sv =====
// collects the lane events of one tick and sends them out in button order
`default_nettype none

module bmpc_merge
  import bmpc_pkg::*;
#(
  parameter int unsigned NUM_LANES = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire lane_evt_t          evt_i [NUM_LANES],
  output logic                    busy_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [IDX_W-1:0]        out_button_index_o,
  output logic                    out_event_kind_o,
  output logic [COUNT_W-1:0]      out_press_count_o,
  output logic                    out_last_event_o
);

  logic [NUM_LANES-1:0] pend_q;
  evt_kind_e            kind_q  [NUM_LANES];
  logic [COUNT_W-1:0]   count_q [NUM_LANES];

  logic [NUM_LANES-1:0] rest;
  logic [IDX_W-1:0]     sel_idx;
  evt_kind_e            sel_kind;
  logic [COUNT_W-1:0]   sel_count;
  logic                 out_free;
  logic                 move;

  logic                 out_valid_q;
  logic [IDX_W-1:0]     out_idx_q;
  evt_kind_e            out_kind_q;
  logic [COUNT_W-1:0]   out_count_q;
  logic                 out_last_q;

  // lowest pending lane wins
  always_comb begin
    sel_idx   = '0;
    sel_kind  = EVT_MULTI;
    sel_count = '0;
    rest      = pend_q;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_idx   = IDX_W'(i);
        sel_kind  = kind_q[i];
        sel_count = count_q[i];
      end
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      if (IDX_W'(i) == sel_idx) begin
        rest[i] = 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign move     = out_free && (pend_q != '0);
  assign busy_o   = (pend_q != '0) && !(move && (rest == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (load_i) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        pend_q[i] <= evt_i[i].valid;
      end
    end else if (move) begin
      pend_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        kind_q[i]  <= evt_i[i].kind;
        count_q[i] <= evt_i[i].count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_idx_q   <= sel_idx;
      out_kind_q  <= sel_kind;
      out_count_q <= sel_count;
      out_last_q  <= (rest == '0);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_button_index_o = out_idx_q;
  assign out_event_kind_o   = out_kind_q;
  assign out_press_count_o  = out_count_q;
  assign out_last_event_o   = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/button_multi_press_classifier_top.sv =====
// top level: config registers, button lanes and event merge
// output: an accepted tick loads its events as pending; the first of them is
//   registered onto the output as soon as the output is free
// throughput: a tick with no event does not stall input; one with events holds
//   off the next tick until its last event leaves, one per cycle without stall
// reset: clears all lane state, sets the first-tick flag, sets release_ticks
//   to 20 and hold_ticks to 120
`default_nettype none

module button_multi_press_classifier_top
  import bmpc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [COUNT_W-1:0]   cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [LEVEL_W-1:0]   in_button_levels_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [IDX_W-1:0]          out_button_index_o,
  output logic                      out_event_kind_o,
  output logic [COUNT_W-1:0]        out_press_count_o,
  output logic                      out_last_event_o
);

  localparam int unsigned NUM_LANES = (NUM_BUTTONS < LANES) ? NUM_BUTTONS : LANES;

  logic               take;
  logic               busy;
  logic               first_q;
  logic [COUNT_W-1:0] release_ticks_q;
  logic [COUNT_W-1:0] hold_ticks_q;
  lane_evt_t          lane_evt [NUM_LANES];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign take        = in_valid_i && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_ticks_q <= RELEASE_TICKS_RST;
      hold_ticks_q    <= HOLD_TICKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RELEASE_TICKS: release_ticks_q <= cfg_data_i;
        CFG_HOLD_TICKS:    hold_ticks_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (take) begin
      first_q <= 1'b0;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bmpc_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .take_i          (take),
      .push_i          (in_button_levels_i[g]),
      .first_i         (first_q),
      .release_ticks_i (release_ticks_q),
      .hold_ticks_i    (hold_ticks_q),
      .evt_o           (lane_evt[g])
    );
  end

  bmpc_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (take),
    .evt_i              (lane_evt),
    .busy_o             (busy),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_button_index_o (out_button_index_o),
    .out_event_kind_o   (out_event_kind_o),
    .out_press_count_o  (out_press_count_o),
    .out_last_event_o   (out_last_event_o)
  );

  // the first tick only latches levels and never produces an event
  a_first_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && first_q) |=> (!out_valid_o && !in_stall_o))
    else $error("event produced by the first tick");

  // events only exist for buttons with pending presses
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_press_count_o != '0))
    else $error("event with zero press count");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_button_index_o) < NUM_LANES))
    else $error("event for a button that does not exist");

endmodule

`default_nettype wire
